/* design/m4mac_pkg.sv */
package m4mac_pkg;

	// Matrix geometry, fixed by the 4-bit element index
	localparam int DIM   = 4;
	localparam int NELEM = DIM * DIM;
	localparam int IDX_W = 4;
	localparam int SEL_W = 2;
	localparam int WORD_W = 32;
	localparam int PROD_W = 2 * WORD_W;
	localparam int SUM_W  = PROD_W + 2;

	// Operation codes
	localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] OP_MULTIPLY   = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NELEM - 1);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// Element write into one cell
	typedef struct packed {
		logic             left_en;
		logic             right_en;
		logic [SEL_W-1:0] addr;
		word_t            data;
	} cell_wr_t;

	// Partial sum moving along the chain
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		sum_t             psum;
	} chain_t;

endpackage

/* design/matrix4_multiply_accumulate_unit.sv */
// 4x4 signed Q16.16 matrix multiplier with chained products.
// Input channel (in_valid/in_ready): op, elem_index, elem_value. A load left
// or load right transfer writes one column-major element. A
// multiply transfer computes left * right and the product replaces left.
// Output channel (out_valid/out_ready): out_index, out_value, out_last; the
// sixteen product elements come in index order, out_last on the final one.
// Flow: a multiply issues one element per cycle into a chain of four
// multiply-add cells (a multiply register and an add register each) and a
// scale stage; the results then leave at up to one per cycle.
// in_ready is low from a multiply transfer until its last result transfers.
// Loads leave the block ready for the next transfer. If the receiver stalls,
// the current result holds on the port and nothing else advances. Reset
// clears both matrices and leaves the block ready for input.
module matrix4_multiply_accumulate_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [m4mac_pkg::IDX_W-1:0]   elem_index,
	input  m4mac_pkg::word_t              elem_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [m4mac_pkg::IDX_W-1:0]   out_index,
	output m4mac_pkg::word_t              out_value,
	output logic                          out_last
);
	import m4mac_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_COPY, ST_EMIT} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  iss_cnt_q;
	logic              iss_done_q;
	logic [IDX_W-1:0]  out_cnt_q;
	word_t             stg_q [NELEM];

	logic              in_xfer;
	logic              out_xfer;
	chain_t            chain [DIM+1];
	cell_wr_t          cell_wr [DIM];
	word_t             copy_col [DIM][DIM];
	logic              res_valid;
	logic [IDX_W-1:0]  res_idx;
	word_t             res_value;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign out_xfer  = out_valid && out_ready;
	assign out_index = out_cnt_q;
	assign out_value = stg_q[out_cnt_q];
	assign out_last  = (out_cnt_q == LAST_IDX);

	// Element issue into the head of the chain
	assign chain[0].valid = (state_q == ST_CALC) && !iss_done_q;
	assign chain[0].idx   = iss_cnt_q;
	assign chain[0].psum  = '0;

	// Cell j holds left column j and right row j
	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			cell_wr[j].left_en  = in_xfer && (op == OP_LOAD_LEFT)
				&& (elem_index[IDX_W-1:SEL_W] == SEL_W'(j));
			cell_wr[j].right_en = in_xfer && (op == OP_LOAD_RIGHT)
				&& (elem_index[SEL_W-1:0] == SEL_W'(j));
			cell_wr[j].addr     = (op == OP_LOAD_LEFT) ? elem_index[SEL_W-1:0]
				: elem_index[IDX_W-1:SEL_W];
			cell_wr[j].data     = elem_value;
			for (int r = 0; r < DIM; r++) copy_col[j][r] = stg_q[j*DIM + r];
		end
	end

	for (genvar j = 0; j < DIM; j++) begin : g_cell
		m4mac_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr        (cell_wr[j]),
			.copy_en   (state_q == ST_COPY),
			.copy_col  (copy_col[j]),
			.chain_in  (chain[j]),
			.chain_out (chain[j+1])
		);
	end

	m4mac_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_in    (chain[DIM]),
		.res_valid (res_valid),
		.res_idx   (res_idx),
		.res_value (res_value)
	);

	// Product staging
	always_ff @(posedge clk) begin
		if (res_valid) stg_q[res_idx] <= res_value;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iss_cnt_q  <= '0;
			iss_done_q <= 1'b0;
			out_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					iss_cnt_q  <= '0;
					iss_done_q <= 1'b0;
					if (in_xfer && (op == OP_MULTIPLY)) state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (!iss_done_q) begin
						iss_cnt_q <= iss_cnt_q + 1'b1;
						if (iss_cnt_q == LAST_IDX) iss_done_q <= 1'b1;
					end
					if (res_valid && (res_idx == LAST_IDX)) state_q <= ST_COPY;
				end
				ST_COPY: begin
					out_cnt_q <= '0;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_xfer) begin
						out_cnt_q <= out_cnt_q + 1'b1;
						if (out_cnt_q == LAST_IDX) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Results reach staging only while a multiply is computing
	a_res_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (state_q == ST_CALC))
		else $error("product element outside multiply");

	// Writeback to the left matrix follows the last product element
	a_copy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> ($past(res_valid) && ($past(res_idx) == LAST_IDX)))
		else $error("writeback without full product");

	// Nothing is issued once all sixteen elements are in the chain
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iss_done_q |-> !chain[0].valid)
		else $error("extra element issued");

	// Input is never taken while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during emission");

endmodule

/* design/m4mac_cell.sv */
module m4mac_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  m4mac_pkg::cell_wr_t wr,
	input  logic                copy_en,
	input  m4mac_pkg::word_t    copy_col [m4mac_pkg::DIM],
	input  m4mac_pkg::chain_t   chain_in,
	output m4mac_pkg::chain_t   chain_out
);
	import m4mac_pkg::*;

	// left column j (indexed by row), right row j (indexed by column)
	word_t left_q  [DIM];
	word_t right_q [DIM];

	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s1;
	chain_t                   chain_s1;
	chain_t                   chain_s2;

	// Element storage: loads and product writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM; i++) begin
				left_q[i]  <= '0;
				right_q[i] <= '0;
			end
		end else begin
			if (copy_en) begin
				for (int i = 0; i < DIM; i++) left_q[i] <= copy_col[i];
			end else if (wr.left_en) begin
				left_q[wr.addr] <= wr.data;
			end
			if (wr.right_en) right_q[wr.addr] <= wr.data;
		end
	end

	// One product term for this element
	assign prod_c = PROD_W'(left_q[chain_in.idx[SEL_W-1:0]])
		* PROD_W'(right_q[chain_in.idx[IDX_W-1:SEL_W]]);

	// Multiply stage, then add into the passing partial sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1  <= '0;
			chain_s1 <= '0;
			chain_s2 <= '0;
		end else begin
			prod_s1        <= prod_c;
			chain_s1       <= chain_in;
			chain_s2.valid <= chain_s1.valid;
			chain_s2.idx   <= chain_s1.idx;
			chain_s2.psum  <= chain_s1.psum + SUM_W'(prod_s1);
		end
	end

	assign chain_out = chain_s2;

endmodule

/* design/m4mac_scale.sv */
module m4mac_scale #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  m4mac_pkg::chain_t                sum_in,
	output logic                             res_valid,
	output logic [m4mac_pkg::IDX_W-1:0]      res_idx,
	output m4mac_pkg::word_t                 res_value
);
	import m4mac_pkg::*;

	sum_t  shifted_c;
	word_t sat_c;
	logic  in_range_c;

	// Floor shift, then clamp to the 32-bit signed range
	assign shifted_c  = sum_in.psum >>> FRAC_BITS;
	assign in_range_c = (shifted_c[SUM_W-1:WORD_W-1] == '0)
		|| (shifted_c[SUM_W-1:WORD_W-1] == '1);

	always_comb begin
		if (in_range_c) begin
			sat_c = shifted_c[WORD_W-1:0];
		end else if (shifted_c[SUM_W-1]) begin
			sat_c = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(WORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= sum_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_idx   <= sum_in.idx;
		res_value <= sat_c;
	end

endmodule
